// ===== rtl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must never hold while out of reset
`define CBR_ASSERT_NEVER(lbl, clk, rstn, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
		else $error("assertion failed: forbidden condition");

// same-cycle implication
`define CBR_ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("assertion failed: implication");

// next-cycle implication
`define CBR_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

// ===== rtl/cbr_pkg.sv =====
`default_nettype none

package cbr_pkg;

	localparam logic [15:0] INIT_RUN_SYMBOLS = 16'd12500;
	localparam logic [15:0] WINDOW_RESET     = 16'd12500;
	localparam logic [15:0] PERIOD_RESET     = 16'd8000;
	localparam logic [15:0] LEN_MAX          = 16'hFFFF;

	localparam logic CFG_WINDOW  = 1'b0;
	localparam logic CFG_PERIOD  = 1'b1;
	localparam logic CMD_UPDATE  = 1'b0;
	localparam logic CMD_REPORT  = 1'b1;

	// divider: 33-bit dividend, 16-bit divisor, 17-bit quotient
	localparam int DIV_NW = 33;
	localparam int DIV_QW = 17;

	typedef struct packed {
		logic              start;
		logic [DIV_NW-1:0] dividend;
		logic [15:0]       divisor;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [DIV_QW-1:0] quotient;
	} div_rsp_t;

endpackage

`default_nettype wire

// ===== rtl/cbr_in_if.sv =====
`default_nettype none

interface cbr_in_if;
	logic        valid;
	logic        ready;
	logic        command;
	logic [47:0] now_ns;
	logic        busy_during_interval;

	modport source (output valid, command, now_ns, busy_during_interval, input ready);
	modport sink (input valid, command, now_ns, busy_during_interval, output ready);
endinterface

`default_nettype wire

// ===== rtl/cbr_out_if.sv =====
`default_nettype none

interface cbr_out_if;
	logic        valid;
	logic        ready;
	logic [15:0] busy_symbols;
	logic [16:0] busy_ratio_q16;

	modport source (output valid, busy_symbols, busy_ratio_q16, input ready);
	modport sink (input valid, busy_symbols, busy_ratio_q16, output ready);
endinterface

`default_nettype wire

// ===== rtl/cbr_div.sv =====
`default_nettype none
`include "assert_macros.svh"

// restoring divider, one quotient bit per cycle; caller guarantees
// dividend < divisor * 2^DIV_QW so the quotient fits
module cbr_div
	import cbr_pkg::*;
(
	input  wire      clk,
	input  wire      arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);
	localparam int CNT_W = $clog2(DIV_QW);
	localparam int RW    = DIV_NW - DIV_QW;

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [RW-1:0]    rem_q;
	logic [DIV_QW-1:0] num_q;
	logic [DIV_QW-1:0] quo_q;
	logic [15:0]      dvs_q;

	logic [RW+1:0]    diff;
	logic             ge;

	assign diff = {1'b0, rem_q, num_q[DIV_QW-1]} - {2'b00, dvs_q};
	assign ge   = !diff[RW+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(DIV_QW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= req.dividend[DIV_NW-1:DIV_QW];
			num_q <= req.dividend[DIV_QW-1:0];
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[RW-1:0] : {rem_q[RW-2:0], num_q[DIV_QW-1]};
			num_q <= {num_q[DIV_QW-2:0], 1'b0};
			quo_q <= {quo_q[DIV_QW-2:0], ge};
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

	`CBR_ASSERT_NEVER(a_div_start_busy, clk, arst_n, req.start && busy_q)
	`CBR_ASSERT_IMPLY(a_div_done_idle, clk, arst_n, done_q, !busy_q)

endmodule

`default_nettype wire

// ===== rtl/cbr_ring.sv =====
`default_nettype none
`include "assert_macros.svh"

// run ring: {busy, length} per entry, one write and one registered read port.
// Entry zero reads as the initial run until it is first written.
module cbr_ring
	import cbr_pkg::*;
#(
	parameter int DEPTH = 64,
	parameter int AW    = 6
) (
	input  wire           clk,
	input  wire           arst_n,
	input  wire           wr_en,
	input  wire  [AW-1:0] wr_addr,
	input  wire  [15:0]   wr_len,
	input  wire           wr_busy,
	input  wire           rd_en,
	input  wire  [AW-1:0] rd_addr,
	output logic [15:0]   rd_len,
	output logic          rd_busy
);
	logic [16:0] mem [DEPTH];
	logic [16:0] rd_q;
	logic        zero_written_q;
	logic        use_init_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= {wr_busy, wr_len};
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zero_written_q <= 1'b0;
			use_init_q     <= 1'b0;
		end else begin
			if (wr_en && wr_addr == '0) begin
				zero_written_q <= 1'b1;
			end
			if (rd_en) begin
				use_init_q <= (rd_addr == '0) && !zero_written_q;
			end
		end
	end

	assign rd_len  = use_init_q ? INIT_RUN_SYMBOLS : rd_q[15:0];
	assign rd_busy = use_init_q ? 1'b0 : rd_q[16];

	`CBR_ASSERT_NEVER(a_ring_rw_same_cycle, clk, arst_n, rd_en && wr_en)

endmodule

`default_nettype wire

// ===== rtl/channel_busy_ratio_window.sv =====
// Channel busy ratio over a sliding window of symbol periods.
// items (sink): command 0 is a medium update with now_ns and the busy state
//   since the previous update; command 1 asks for a report.
// results (source): one item per report, busy_symbols and busy_ratio_q16
//   (busy / window as an unsigned Q16 fraction). Updates return nothing.
// cfg_we / cfg_index / cfg_wdata: index 0 window_symbols, 1 symbol_period_ns.
// One item is worked at a time; items.ready is high only when idle.
// Update: after the item is taken: check, divide start, the divide steps, done,
//   push, idle; no push when under one symbol, no divide when saturated.
// Report: a read state and an accumulate state per run walked (the ring
//   read is registered on the single read port), then the divide and the
//   output register. Update and report share one bit-serial divider.
// The result sits in an output register; new items are taken while it
// waits. A report that finishes while the previous result is still not
// taken waits until the receiver takes it.
// Reset: window 12500, period 8000, ring holds one idle run of 12500
// symbols, timestamp zero. No clearing pass is needed.
`default_nettype none
`include "assert_macros.svh"

module channel_busy_ratio_window
	import cbr_pkg::*;
#(
	parameter int RUN_DEPTH = 64
) (
	input  wire        clk,
	input  wire        arst_n,
	cbr_in_if.sink     items,
	cbr_out_if.source  results,
	input  wire        cfg_we,
	input  wire        cfg_index,
	input  wire [15:0] cfg_wdata
);
	localparam int AW = $clog2(RUN_DEPTH);
	localparam int CW = $clog2(RUN_DEPTH + 1);

	typedef enum logic [8:0] {
		ST_IDLE      = 9'b000000001,
		ST_UPD_CHK   = 9'b000000010,
		ST_UPD_DIV   = 9'b000000100,
		ST_PUSH      = 9'b000001000,
		ST_RD        = 9'b000010000,
		ST_ACC       = 9'b000100000,
		ST_RPT_START = 9'b001000000,
		ST_RPT_DIV   = 9'b010000000,
		ST_FINISH    = 9'b100000000
	} state_t;

	state_t         state_q;

	// config
	logic [15:0]    window_q;
	logic [15:0]    period_q;
	logic [15:0]    period_eff;

	// ring bookkeeping
	logic [AW-1:0]  newest_q;
	logic [CW-1:0]  count_q;
	logic [47:0]    last_q;
	logic [AW-1:0]  newest_inc;

	// update work
	logic [47:0]    delta_q;
	logic [47:0]    now_q;
	logic           ubusy_q;
	logic [15:0]    syms_q;
	logic           sat;

	// report walk
	logic [AW-1:0]  idx_q;
	logic [CW-1:0]  walk_q;
	logic [15:0]    total_q;
	logic [15:0]    bsum_q;
	logic [16:0]    total_n;
	logic           crosses;
	logic [AW-1:0]  idx_dec;

	// output register
	logic           out_valid_q;
	logic [15:0]    out_busy_q;
	logic [16:0]    out_ratio_q;
	logic [16:0]    ratio_q;
	logic           can_load;
	logic           load_out;

	// ring / divider
	logic [15:0]    rd_len;
	logic           rd_busy;
	div_req_t       div_req;
	div_rsp_t       div_rsp;

	logic           accept;

	assign accept     = items.valid && items.ready;
	assign items.ready = (state_q == ST_IDLE);
	assign period_eff = (period_q == '0) ? 16'd1 : period_q;
	assign newest_inc = (newest_q == AW'(RUN_DEPTH - 1)) ? '0 : newest_q + 1'b1;
	assign idx_dec    = (idx_q == '0) ? AW'(RUN_DEPTH - 1) : idx_q - 1'b1;
	assign sat        = (delta_q >= {16'h0, period_eff, 16'h0});
	assign total_n    = {1'b0, total_q} + {1'b0, rd_len};
	assign crosses    = (total_n >= {1'b0, window_q});
	assign can_load   = !out_valid_q || results.ready;
	// finished report moves into the output register
	assign load_out   = (state_q == ST_FINISH) && can_load;

	always_comb begin
		div_req.start    = (state_q == ST_UPD_CHK && !sat) || (state_q == ST_RPT_START);
		div_req.dividend = (state_q == ST_RPT_START) ? {1'b0, bsum_q, 16'h0}
		                                             : {1'b0, delta_q[31:0]};
		div_req.divisor  = (state_q == ST_RPT_START) ? window_q : period_eff;
	end

	cbr_ring #(
		.DEPTH (RUN_DEPTH),
		.AW    (AW)
	) u_ring (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (state_q == ST_PUSH),
		.wr_addr (newest_inc),
		.wr_len  (syms_q),
		.wr_busy (ubusy_q),
		.rd_en   (state_q == ST_RD),
		.rd_addr (idx_q),
		.rd_len  (rd_len),
		.rd_busy (rd_busy)
	);

	cbr_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			window_q    <= WINDOW_RESET;
			period_q    <= PERIOD_RESET;
			newest_q    <= '0;
			count_q     <= CW'(1);
			last_q      <= '0;
			walk_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_WINDOW: window_q <= cfg_wdata;
					CFG_PERIOD: period_q <= cfg_wdata;
					default:    ;
				endcase
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						walk_q <= '0;
						if (items.command == CMD_UPDATE) begin
							state_q <= ST_UPD_CHK;
						end else if (count_q == '0) begin
							state_q <= ST_RPT_START;
						end else begin
							state_q <= ST_RD;
						end
					end
				end
				ST_UPD_CHK: state_q <= sat ? ST_PUSH : ST_UPD_DIV;
				ST_UPD_DIV: begin
					if (div_rsp.done) begin
						// less than one symbol: nothing changes
						state_q <= (div_rsp.quotient == '0) ? ST_IDLE : ST_PUSH;
					end
				end
				ST_PUSH: begin
					newest_q <= newest_inc;
					last_q   <= now_q;
					if (count_q != CW'(RUN_DEPTH)) begin
						count_q <= count_q + 1'b1;
					end
					state_q <= ST_IDLE;
				end
				ST_RD: state_q <= ST_ACC;
				ST_ACC: begin
					if (crosses) begin
						// crossing run and all older ones are dropped
						count_q <= walk_q;
						state_q <= ST_RPT_START;
					end else begin
						walk_q <= walk_q + 1'b1;
						state_q <= (walk_q + 1'b1 == count_q) ? ST_RPT_START : ST_RD;
					end
				end
				ST_RPT_START: state_q <= ST_RPT_DIV;
				ST_RPT_DIV: begin
					if (div_rsp.done) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (can_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				delta_q <= items.now_ns - last_q;
				now_q   <= items.now_ns;
				ubusy_q <= items.busy_during_interval;
				idx_q   <= newest_q;
				total_q <= '0;
				bsum_q  <= '0;
			end
			ST_UPD_CHK: begin
				if (sat) begin
					syms_q <= LEN_MAX;
				end
			end
			ST_UPD_DIV: begin
				if (div_rsp.done) begin
					syms_q <= div_rsp.quotient[15:0];
				end
			end
			ST_ACC: begin
				if (crosses) begin
					if (rd_busy) begin
						bsum_q <= bsum_q + (window_q - total_q);
					end
				end else begin
					total_q <= total_n[15:0];
					idx_q   <= idx_dec;
					if (rd_busy) begin
						bsum_q <= bsum_q + rd_len;
					end
				end
			end
			ST_RPT_DIV: begin
				if (div_rsp.done) begin
					ratio_q <= (window_q == '0) ? '0 : div_rsp.quotient;
				end
			end
			ST_FINISH: begin
				if (can_load) begin
					out_busy_q  <= bsum_q;
					out_ratio_q <= ratio_q;
				end
			end
			default: ;
		endcase
	end

	assign results.valid          = out_valid_q;
	assign results.busy_symbols   = out_busy_q;
	assign results.busy_ratio_q16 = out_ratio_q;

	`CBR_ASSERT_NEVER(a_count_range, clk, arst_n, count_q > CW'(RUN_DEPTH))
	`CBR_ASSERT_NEXT(a_accept_leaves_idle, clk, arst_n, accept, state_q != ST_IDLE)
	`CBR_ASSERT_IMPLY(a_walk_bound, clk, arst_n, state_q == ST_ACC, walk_q < count_q)

endmodule

`default_nettype wire

// ===== dv/channel_busy_ratio_window_test.sv =====
`timescale 1ns / 100ps

module channel_busy_ratio_window_test;
	import cbr_pkg::*;

	localparam int DEPTH         = 64;
	localparam int LIMIT_CYCLES  = 1_500_000;
	// an update may still be in flight after the last report result
	localparam int SETTLE_CYCLES = 40;
	// longest report: a read and an accumulate state per run plus the divide, with margin
	localparam int DRAIN_CYCLES  = 200;
	localparam int HOLD_CYCLES   = 1500;
	localparam int TARGET_ITEMS  = 900;
	localparam int MIN_REPORTS   = 60;
	localparam int PHASE_ITEMS   = 120;

	typedef struct packed {
		logic [15:0] busy_symbols;
		logic [16:0] busy_ratio_q16;
	} report_t;

	typedef enum logic [1:0] {ROW_CFG, ROW_UPDATE, ROW_REPORT} row_kind_e;

	// one line of the directed table; typed rows carry a hand-written result
	typedef struct {
		row_kind_e   kind;
		logic        cfg_index;
		logic [15:0] cfg_value;
		logic [47:0] now_ns;
		logic        busy;
		bit          typed;
		report_t     typed_result;
	} row_t;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        cfg_we    = 1'b0;
	logic        cfg_index = CFG_WINDOW;
	logic [15:0] cfg_wdata = '0;

	cbr_in_if  in_ch ();
	cbr_out_if out_ch ();

	channel_busy_ratio_window #(.RUN_DEPTH(DEPTH)) u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.items     (in_ch),
		.results   (out_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// ---------------------------------------------------------------------
	// Busy-ratio predictor: ring of (length, busy) runs plus the timestamp
	// of the last accepted push, mirrored at the block's widths.
	// ---------------------------------------------------------------------
	logic [15:0] run_len_m [DEPTH];
	bit          run_busy_m [DEPTH];
	int unsigned newest_run;
	int unsigned live_runs;
	logic [47:0] stamp_ns;
	logic [15:0] window_cfg = WINDOW_RESET;
	logic [15:0] period_cfg = PERIOD_RESET;

	report_t expected_reports [$];

	int unsigned mismatches     = 0;
	int unsigned reports_seen   = 0;
	int unsigned reports_sent   = 0;
	int unsigned runs_pushed    = 0;
	int unsigned items_counted  = 0;
	int unsigned settings_used  = 0;
	int unsigned cycles         = 0;

	initial begin
		for (int i = 0; i < DEPTH; i++) begin
			run_len_m[i] = '0;
			run_busy_m[i] = 1'b0;
		end
		run_len_m[0] = INIT_RUN_SYMBOLS;
		newest_run = 0;
		live_runs = 1;
		stamp_ns = '0;
	end

	// Medium update: whole symbols since the last push. Sub-symbol intervals
	// leave everything alone, including the timestamp. Backward time wraps
	// modulo 2^48 and so saturates. Returns 1 when a run was pushed.
	function automatic bit push_interval(input logic [47:0] now, input logic busy);
		logic [47:0] period;
		logic [47:0] elapsed;
		logic [47:0] whole;
		period = (period_cfg == 16'd0) ? 48'd1 : {32'd0, period_cfg};
		elapsed = now - stamp_ns;
		if (elapsed < period)
			return 1'b0;
		whole = elapsed / period;
		newest_run = (newest_run + 1) % DEPTH;
		run_len_m[newest_run] = (whole > 48'hFFFF) ? LEN_MAX : whole[15:0];
		run_busy_m[newest_run] = busy;
		if (live_runs < DEPTH)
			live_runs++;
		stamp_ns = now;
		return 1'b1;
	endfunction

	// Report: newest run first. The run that reaches the window edge counts
	// only its in-window part, and it and everything older is dropped.
	function automatic report_t walk_window();
		report_t         res;
		longint unsigned win;
		longint unsigned total;
		longint unsigned prior;
		longint unsigned busy;
		int unsigned     idx;
		int unsigned     n;
		win = window_cfg;
		total = 0;
		busy = 0;
		idx = newest_run;
		n = live_runs;
		for (int unsigned walked = 0; walked < n; walked++) begin
			prior = total;
			total += run_len_m[idx];
			if (total < win) begin
				if (run_busy_m[idx])
					busy += run_len_m[idx];
			end else begin
				if (run_busy_m[idx])
					busy += win - prior;
				live_runs = walked;
				break;
			end
			idx = (idx + DEPTH - 1) % DEPTH;
		end
		res.busy_symbols = busy[15:0];
		res.busy_ratio_q16 = (win == 0) ? 17'd0 : 17'((busy << 16) / win);
		return res;
	endfunction

	// mostly short gaps, some medium, a few long ones
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return $urandom_range(0, 2);
		else if (r < 95)
			return $urandom_range(3, 10);
		return $urandom_range(20, 120);
	endfunction

	// quiet stretches during which neither side idles
	bit calm;
	assign calm = ((cycles >> 10) % 5) == 0;

	always @(posedge clk)
		cycles <= cycles + 1;

	initial begin
		wait (cycles >= LIMIT_CYCLES);
		$display("timeout after %0d cycles, %0d reports still pending",
			cycles, expected_reports.size());
		$display("TB_ERROR");
		$finish;
	end

	// ---------------------------------------------------------------------
	// Result side: checks every accepted item against the oldest pending
	// report, and drives ready with random holds plus one long hold.
	// ---------------------------------------------------------------------
	int unsigned ready_gap    = 0;
	int unsigned hold_left    = 0;
	bit          hold_request = 1'b0;
	bit          hold_done    = 1'b0;

	task automatic note_mismatch(input string field, input int unsigned want,
			input int unsigned got);
		mismatches++;
		if (mismatches <= 10)
			$display("mismatch on %s at %0t: expected %0d, got %0d", field, $realtime, want, got);
	endtask

	initial out_ch.ready = 1'b0;

	always @(posedge clk) begin
		report_t got;
		report_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			got = {out_ch.busy_symbols, out_ch.busy_ratio_q16};
			if (expected_reports.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("result with nothing pending at %0t: busy %0d ratio %0d",
						$realtime, got.busy_symbols, got.busy_ratio_q16);
			end else begin
				want = expected_reports.pop_front();
				reports_seen++;
				if (got.busy_symbols != want.busy_symbols)
					note_mismatch("busy_symbols", want.busy_symbols, got.busy_symbols);
				if (got.busy_ratio_q16 != want.busy_ratio_q16)
					note_mismatch("busy_ratio_q16", want.busy_ratio_q16, got.busy_ratio_q16);
			end
		end

		if (hold_left != 0) begin
			hold_left--;
			out_ch.ready <= 1'b0;
		end else if (hold_request && !hold_done) begin
			// long hold: the output register fills and the block stops taking items
			hold_done = 1'b1;
			hold_left = HOLD_CYCLES - 1;
			out_ch.ready <= 1'b0;
		end else if (ready_gap != 0) begin
			ready_gap--;
			out_ch.ready <= 1'b0;
		end else if (!calm && $urandom_range(0, 3) == 0) begin
			ready_gap = pick_gap();
			out_ch.ready <= 1'b0;
		end else begin
			out_ch.ready <= 1'b1;
		end
	end

	// ---------------------------------------------------------------------
	// Item side
	// ---------------------------------------------------------------------
	bit offering = 1'b0;

	initial begin
		in_ch.valid = 1'b0;
		in_ch.command = CMD_UPDATE;
		in_ch.now_ns = '0;
		in_ch.busy_during_interval = 1'b0;
	end

	// valid gets at most one nonblocking write per time step
	task automatic lower_valid();
		if (offering) begin
			in_ch.valid <= 1'b0;
			offering = 1'b0;
		end
	endtask

	// Offer one item, wait for it to be taken, then run the predictor.
	// A typed row replaces the predicted result with its own.
	task automatic offer(input logic cmd, input logic [47:0] now, input logic busy,
			input bit typed, input report_t typed_res);
		int unsigned gap;
		report_t     res;
		gap = calm ? 0 : pick_gap();
		if (gap != 0) begin
			lower_valid();
			repeat (gap) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.command <= cmd;
		in_ch.now_ns <= now;
		in_ch.busy_during_interval <= busy;
		offering = 1'b1;
		do @(posedge clk); while (!in_ch.ready);
		if (cmd == CMD_REPORT) begin
			res = walk_window();
			expected_reports.push_back(typed ? typed_res : res);
			reports_sent++;
			items_counted++;
		end else if (push_interval(now, busy)) begin
			runs_pushed++;
			items_counted++;
		end
	endtask

	// stop offering and wait until every pending report is back
	task automatic drain(input int unsigned extra);
		lower_valid();
		while (expected_reports.size() != 0)
			@(posedge clk);
		repeat (extra) @(posedge clk);
	endtask

	// only called with the block idle; cfg_we goes low between writes to keep them apart
	task automatic write_reg(input logic idx, input logic [15:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_WINDOW)
			window_cfg = val;
		else
			period_cfg = val;
		@(posedge clk);
	endtask

	// Next update time: mostly whole symbols up to span past the last push,
	// with some sub-symbol steps, jumps anywhere (often backwards) and
	// intervals long enough to saturate the run length.
	function automatic logic [47:0] next_time(input int unsigned span);
		longint unsigned period;
		longint unsigned step;
		logic [63:0]     wide;
		int unsigned     r;
		period = (period_cfg == 16'd0) ? 1 : period_cfg;
		r = $urandom_range(0, 99);
		if (r < 8) begin
			step = $urandom_range(0, period - 1);
		end else if (r < 12) begin
			wide = {$urandom, $urandom};
			return wide[47:0];
		end else if (r < 16) begin
			step = (65536 + $urandom_range(0, 100000)) * period + $urandom_range(0, period - 1);
		end else begin
			step = $urandom_range(1, span) * period + $urandom_range(0, period - 1);
		end
		return stamp_ns + step[47:0];
	endfunction

	function automatic logic [47:0] any_time();
		logic [63:0] wide;
		wide = {$urandom, $urandom};
		return wide[47:0];
	endfunction

	function automatic row_t mk_row(input row_kind_e kind, input logic idx,
			input logic [15:0] val, input logic [47:0] now, input logic busy,
			input bit typed, input logic [15:0] exp_busy, input logic [16:0] exp_ratio);
		row_t row;
		row.kind = kind;
		row.cfg_index = idx;
		row.cfg_value = val;
		row.now_ns = now;
		row.busy = busy;
		row.typed = typed;
		row.typed_result = {exp_busy, exp_ratio};
		return row;
	endfunction

	initial begin
		row_t        rows [$];
		int unsigned phase;
		int unsigned next_phase_at;
		int unsigned pick;
		int unsigned n;
		int unsigned span;
		bit          pause_pending;
		logic [15:0] win;
		logic [15:0] per;

		// Directed table. Starts from reset: window 12500, period 8000 and a
		// single idle run of 12500 symbols at time zero.
		// idle reset run exactly fills the window: crossing run, nothing busy
		rows.push_back(mk_row(ROW_REPORT, CFG_WINDOW, 0, 0, 0, 1, 16'd0, 17'd0));
		// that run was dropped, so the ring is empty
		rows.push_back(mk_row(ROW_REPORT, CFG_WINDOW, 0, 0, 0, 1, 16'd0, 17'd0));
		// 99 busy symbols
		rows.push_back(mk_row(ROW_UPDATE, CFG_WINDOW, 0, 48'd799999, 1, 0, 0, 0));
		// less than one symbol later: ignored, timestamp kept
		rows.push_back(mk_row(ROW_UPDATE, CFG_WINDOW, 0, 48'd807998, 1, 0, 0, 0));
		// time goes backwards: wraps, saturates to 65535 busy symbols
		rows.push_back(mk_row(ROW_UPDATE, CFG_WINDOW, 0, 48'd0, 1, 0, 0, 0));
		// saturated busy run covers the whole window: ratio of exactly one
		rows.push_back(mk_row(ROW_REPORT, CFG_WINDOW, 0, 0, 0, 1, 16'd12500, 17'd65536));
		rows.push_back(mk_row(ROW_REPORT, CFG_WINDOW, 0, 0, 0, 1, 16'd0, 17'd0));
		rows.push_back(mk_row(ROW_CFG, CFG_WINDOW, 16'hFFFF, 0, 0, 0, 0, 0));
		rows.push_back(mk_row(ROW_CFG, CFG_PERIOD, 16'd1, 0, 0, 0, 0, 0));
		// long interval forward to the top of the time range
		rows.push_back(mk_row(ROW_UPDATE, CFG_WINDOW, 0, 48'hFFFF_FFFF_FFFF, 1, 0, 0, 0));
		rows.push_back(mk_row(ROW_REPORT, CFG_WINDOW, 0, 0, 0, 1, 16'hFFFF, 17'd65536));
		// time wraps past 2^48: three idle symbols
		rows.push_back(mk_row(ROW_UPDATE, CFG_WINDOW, 0, 48'd2, 0, 0, 0, 0));
		// zero window: newest run always crosses, result zero
		rows.push_back(mk_row(ROW_CFG, CFG_WINDOW, 16'd0, 0, 0, 0, 0, 0));
		rows.push_back(mk_row(ROW_REPORT, CFG_WINDOW, 0, 0, 0, 1, 16'd0, 17'd0));
		// zero period counts as one nanosecond: five busy symbols
		rows.push_back(mk_row(ROW_CFG, CFG_PERIOD, 16'd0, 0, 0, 0, 0, 0));
		rows.push_back(mk_row(ROW_UPDATE, CFG_WINDOW, 0, 48'd7, 1, 0, 0, 0));
		rows.push_back(mk_row(ROW_CFG, CFG_WINDOW, 16'd1, 0, 0, 0, 0, 0));
		rows.push_back(mk_row(ROW_REPORT, CFG_WINDOW, 0, 0, 0, 1, 16'd1, 17'd65536));
		// widest period; two idle then three busy symbols, window of four:
		// the idle run crosses the edge
		rows.push_back(mk_row(ROW_CFG, CFG_PERIOD, 16'hFFFF, 0, 0, 0, 0, 0));
		rows.push_back(mk_row(ROW_UPDATE, CFG_WINDOW, 0, 48'd131077, 0, 0, 0, 0));
		rows.push_back(mk_row(ROW_UPDATE, CFG_WINDOW, 0, 48'd327782, 1, 0, 0, 0));
		rows.push_back(mk_row(ROW_CFG, CFG_WINDOW, 16'd4, 0, 0, 0, 0, 0));
		rows.push_back(mk_row(ROW_REPORT, CFG_WINDOW, 0, 0, 0, 0, 0, 0));

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[i]) begin
			case (rows[i].kind)
				ROW_CFG: begin
					drain(SETTLE_CYCLES);
					write_reg(rows[i].cfg_index, rows[i].cfg_value);
					settings_used++;
				end
				ROW_UPDATE: begin
					offer(CMD_UPDATE, rows[i].now_ns, rows[i].busy, 1'b0, '0);
				end
				default: begin
					offer(CMD_REPORT, any_time(), 1'($urandom_range(0, 1)), rows[i].typed,
						rows[i].typed_result);
				end
			endcase
		end

		// Random part in phases of register settings. Most traffic is runs of
		// updates closed by a report, some of them long enough to wrap the
		// ring; the rest is lone reports and noise.
		phase = 0;
		next_phase_at = 0;
		pause_pending = 1'b0;
		while (items_counted < TARGET_ITEMS || reports_sent < MIN_REPORTS) begin
			if (items_counted >= next_phase_at) begin
				case (phase % 6)
					0: begin
						win = WINDOW_RESET;
						per = PERIOD_RESET;
					end
					1: begin
						win = 16'd1;
						per = 16'd1;
					end
					2: begin
						win = 16'hFFFF;
						per = 16'hFFFF;
					end
					3: begin
						win = 16'hFFFF;
						per = 16'd1;
					end
					4: begin
						win = 16'($urandom_range(1, 300));
						per = 16'($urandom_range(1, 65535));
					end
					default: begin
						win = 16'($urandom_range(1, 65535));
						per = 16'($urandom_range(1, 20));
					end
				endcase
				drain(SETTLE_CYCLES);
				write_reg(CFG_WINDOW, win);
				write_reg(CFG_PERIOD, per);
				settings_used++;
				// receiver goes quiet for a long stretch while items keep coming
				if (phase == 2)
					hold_request <= 1'b1;
				pause_pending = (phase == 4);
				next_phase_at = items_counted + PHASE_ITEMS;
				phase++;
			end

			// halfway through one phase the sender waits for every result
			if (pause_pending && items_counted + PHASE_ITEMS / 2 >= next_phase_at) begin
				drain(0);
				pause_pending = 1'b0;
			end

			pick = $urandom_range(0, 99);
			if (pick < 75) begin
				n = ($urandom_range(0, 99) < 15) ? $urandom_range(60, 80) : $urandom_range(1, 6);
				span = (window_cfg == 0) ? 8 : window_cfg / $urandom_range(1, 2 * n);
				if (span == 0)
					span = 1;
				repeat (n)
					offer(CMD_UPDATE, next_time(span), 1'($urandom_range(0, 1)), 1'b0, '0);
				offer(CMD_REPORT, any_time(), 1'($urandom_range(0, 1)), 1'b0, '0);
			end else if (pick < 90) begin
				offer(CMD_REPORT, any_time(), 1'($urandom_range(0, 1)), 1'b0, '0);
			end else begin
				offer(1'($urandom_range(0, 1)), any_time(), 1'($urandom_range(0, 1)), 1'b0, '0);
			end
		end

		drain(DRAIN_CYCLES);
		$display("ran %0d register settings, %0d runs pushed, %0d reports checked",
			settings_used, runs_pushed, reports_seen);
		$display("%0d field mismatches, %0d reports still pending",
			mismatches, expected_reports.size());
		if (mismatches == 0 && expected_reports.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
